// ===== design/adu_pkg.sv =====
`default_nettype none

package adu_pkg;

    localparam int CURV_W      = 32;
    localparam int DIR_W       = 16;
    localparam int MAG_W       = 40;
    localparam int RATIO_CELLS = 32;
    localparam int ROOT_CELLS  = 32;
    localparam int NORM_STEPS  = 6;
    localparam int QUO_CELLS   = DIR_W - 1;
    localparam int UNIT_LAT    = NORM_STEPS + 2 + ROOT_CELLS + QUO_CELLS;
    localparam int PIPE_LAST   = RATIO_CELLS + 1 + ROOT_CELLS + 2 + UNIT_LAT;

    // How the curvature ratio is chosen once the divider chain is done.
    typedef enum logic [1:0] {
        RSEL_DIV  = 2'b00,
        RSEL_ZERO = 2'b01,
        RSEL_MAX  = 2'b10
    } t_rsel;

    typedef struct packed {
        t_rsel                       rsel;
        logic [CURV_W-1:0]           k1m;
        logic [2:0][DIR_W-1:0]       d1;
        logic [2:0][DIR_W-1:0]       d2;
    } t_rsb;

    typedef struct packed {
        logic [2:0][DIR_W-1:0]       d1;
        logic [2:0][DIR_W-1:0]       d2;
    } t_dsb;

    typedef struct packed {
        logic [2:0]                  neg;
        logic [2:0][30:0]            mag;
    } t_vsb;

    typedef struct packed {
        logic                        hyp;
        logic [2:0][DIR_W-1:0]       plus;
        logic [2:0][DIR_W-1:0]       minus;
    } t_res;

endpackage

`default_nettype wire

// ===== design/adu_div_cell.sv =====
`default_nettype none

module adu_div_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_rem,
    input  logic [31:0] i_div,
    input  logic [31:0] i_quo,
    input  logic        i_bit,
    output logic [32:0] o_rem,
    output logic [31:0] o_div,
    output logic [31:0] o_quo
);

    logic        w_ge;
    logic [32:0] w_diff;
    logic [32:0] n_rem;
    logic [31:0] n_quo;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [31:0] r_quo;

    // One restoring step: the kept remainder is always below the divisor.
    always_comb begin
        w_ge   = i_rem >= {1'b0, i_div};
        w_diff = i_rem - {1'b0, i_div};
        n_rem  = w_ge ? {w_diff[31:0], i_bit} : {i_rem[31:0], i_bit};
        n_quo  = {i_quo[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

// ===== design/adu_sqrt_cell.sv =====
`default_nettype none

module adu_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [33:0] i_rem,
    input  logic [31:0] i_root,
    input  logic [63:0] i_rad,
    output logic [33:0] o_rem,
    output logic [31:0] o_root,
    output logic [63:0] o_rad
);

    logic [35:0] w_cur;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;
    logic [33:0] n_rem;
    logic [31:0] n_root;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_rad;

    always_comb begin
        w_cur   = {i_rem, i_rad[63:62]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_cur - w_trial;
        w_ge    = w_cur >= w_trial;
        n_rem   = w_ge ? w_diff[33:0] : w_cur[33:0];
        n_root  = {i_root[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[61:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

`default_nettype wire

// ===== design/adu_unit3.sv =====
`default_nettype none

module adu_unit3 (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [2:0][adu_pkg::MAG_W-1:0]         i_mag,
    input  logic [2:0]                             i_neg,
    output logic [2:0][adu_pkg::DIR_W-1:0]         o_comp
);

    localparam int NS = adu_pkg::NORM_STEPS;
    localparam int RC = adu_pkg::ROOT_CELLS;
    localparam int QC = adu_pkg::QUO_CELLS;

    logic [2:0][adu_pkg::MAG_W-1:0] w_nsrc [0:NS-1];
    logic [2:0][adu_pkg::MAG_W-1:0] n_nm   [0:NS-1];
    logic [2:0][adu_pkg::MAG_W-1:0] r_nm   [0:NS-1];
    logic [2:0]                     r_nneg [0:NS-1];

    logic [2:0][61:0]               r_sq;
    adu_pkg::t_vsb                  r_sq_sb;
    logic [63:0]                    r_sum;
    adu_pkg::t_vsb                  r_sum_sb;
    adu_pkg::t_vsb                  r_rt_sb [0:RC-1];
    logic [2:0]                     r_dv_neg [0:QC-1];

    logic [33:0] w_rt_rem  [0:RC];
    logic [31:0] w_rt_root [0:RC];
    logic [63:0] w_rt_rad  [0:RC];

    logic [32:0] w_dv_rem [0:QC][0:2];
    logic [31:0] w_dv_div [0:QC][0:2];
    logic [31:0] w_dv_quo [0:QC][0:2];

    logic [2:0][30:0] w_m;

    // Leading-zero normalization: the largest magnitude ends with its top bit at
    // bit 39, and bits 39:9 then hold it in [2^30, 2^31).
    for (genvar k = 0; k < NS; k++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - k);
        logic [adu_pkg::MAG_W-1:0] w_or;
        if (k == 0) begin : g_first
            assign w_nsrc[k] = i_mag;
        end else begin : g_next
            assign w_nsrc[k] = r_nm[k-1];
        end
        assign w_or = w_nsrc[k][0] | w_nsrc[k][1] | w_nsrc[k][2];
        for (genvar c = 0; c < 3; c++) begin : g_comp
            assign n_nm[k][c] = (w_or[adu_pkg::MAG_W-1 -: SH] == '0) ?
                                (w_nsrc[k][c] << SH) : w_nsrc[k][c];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_m
        assign w_m[c] = r_nm[NS-1][c][adu_pkg::MAG_W-1 -: 31];
    end

    assign w_rt_rem[0]  = '0;
    assign w_rt_root[0] = '0;
    assign w_rt_rad[0]  = r_sum;

    for (genvar j = 0; j < RC; j++) begin : g_root
        adu_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_rt_rem[j]),
            .i_root (w_rt_root[j]),
            .i_rad  (w_rt_rad[j]),
            .o_rem  (w_rt_rem[j+1]),
            .o_root (w_rt_root[j+1]),
            .o_rad  (w_rt_rad[j+1])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_dv0
        assign w_dv_rem[0][c] = {2'b00, r_rt_sb[RC-1].mag[c]};
        assign w_dv_div[0][c] = w_rt_root[RC];
        assign w_dv_quo[0][c] = '0;
    end

    for (genvar j = 0; j < QC; j++) begin : g_quo
        for (genvar c = 0; c < 3; c++) begin : g_lane
            adu_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rem (w_dv_rem[j][c]),
                .i_div (w_dv_div[j][c]),
                .i_quo (w_dv_quo[j][c]),
                .i_bit (1'b0),
                .o_rem (w_dv_rem[j+1][c]),
                .o_div (w_dv_div[j+1][c]),
                .o_quo (w_dv_quo[j+1][c])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_nm[k] <= n_nm[k];
            end
            r_nneg[0] <= i_neg;
            for (int k = 1; k < NS; k++) begin
                r_nneg[k] <= r_nneg[k-1];
            end
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= 62'(w_m[c]) * 62'(w_m[c]);
            end
            r_sq_sb.mag <= w_m;
            r_sq_sb.neg <= r_nneg[NS-1];
            r_sum    <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_sum_sb <= r_sq_sb;
            r_rt_sb[0] <= r_sum_sb;
            for (int j = 1; j < RC; j++) begin
                r_rt_sb[j] <= r_rt_sb[j-1];
            end
            r_dv_neg[0] <= r_rt_sb[RC-1].neg;
            for (int j = 1; j < QC; j++) begin
                r_dv_neg[j] <= r_dv_neg[j-1];
            end
        end
    end

    // A zero root means all three magnitudes were zero.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (w_dv_div[QC][c] == '0) begin
                o_comp[c] = '0;
            end else if (r_dv_neg[QC-1][c]) begin
                o_comp[c] = adu_pkg::DIR_W'(-{1'b0, w_dv_quo[QC][c][QC-1:0]});
            end else begin
                o_comp[c] = {1'b0, w_dv_quo[QC][c][QC-1:0]};
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/asymptotic_direction_unit_top.sv =====
`default_nettype none

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_curv_*, i_gauss_curv, i_dir_major_*, i_dir_minor_*
// output    o_out_valid / i_out_ready    o_is_hyperbolic, o_asym_plus_*, o_asym_minus_*
//
// One word is accepted per cycle while the skid register is empty.
// The pipeline is built mainly from the 32-cell ratio divider, the two 32-cell square-root chains
// and the 15-cell quotient chain, one result bit per cell.
// Reset is synchronous and clears only the valid bits and the output handshake state.
// A stalled output parks one word in a skid register; the pipeline freezes while it is full.

module asymptotic_direction_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_curv_major,
    input  logic signed [31:0] i_curv_minor,
    input  logic signed [31:0] i_gauss_curv,
    input  logic signed [15:0] i_dir_major_x,
    input  logic signed [15:0] i_dir_major_y,
    input  logic signed [15:0] i_dir_major_z,
    input  logic signed [15:0] i_dir_minor_x,
    input  logic signed [15:0] i_dir_minor_y,
    input  logic signed [15:0] i_dir_minor_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_is_hyperbolic,
    output logic signed [15:0] o_asym_plus_x,
    output logic signed [15:0] o_asym_plus_y,
    output logic signed [15:0] o_asym_plus_z,
    output logic signed [15:0] o_asym_minus_x,
    output logic signed [15:0] o_asym_minus_y,
    output logic signed [15:0] o_asym_minus_z
);

    localparam int RA   = adu_pkg::RATIO_CELLS;
    localparam int RC   = adu_pkg::ROOT_CELLS;
    localparam int LAST = adu_pkg::PIPE_LAST;
    localparam int MW   = adu_pkg::MAG_W;

    logic w_en;
    logic w_accept;

    logic r_v   [0:LAST];
    logic r_hyp [0:LAST];

    logic [31:0]    w_k1u, w_k2u, w_k1m, w_k2m;
    adu_pkg::t_rsel w_rsel;

    adu_pkg::t_rsb  r_rsb [0:RA];
    logic [31:0]    r_k2m;

    logic [32:0] w_ra_rem [0:RA];
    logic [31:0] w_ra_div [0:RA];
    logic [31:0] w_ra_quo [0:RA];
    logic        w_ra_bit [0:RA-1];

    logic [31:0]    r_ratio;
    adu_pkg::t_dsb  r_rd;

    logic [33:0] w_rt_rem  [0:RC];
    logic [31:0] w_rt_root [0:RC];
    logic [63:0] w_rt_rad  [0:RC];
    adu_pkg::t_dsb r_tsb [0:RC-1];

    logic signed [40:0] r_off [0:2];
    logic [2:0][15:0]   r_md1;

    logic [2:0][MW-1:0] r_pmag, r_mmag;
    logic [2:0]         r_pneg, r_mneg;

    logic [2:0][15:0] w_plus, w_minus;

    adu_pkg::t_res w_last;
    adu_pkg::t_res r_out;
    adu_pkg::t_res r_skid;
    logic          r_out_valid;
    logic          r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;
    assign w_accept   = i_in_valid && o_in_ready;

    // Input stage: magnitudes and the special cases of the ratio.
    always_comb begin
        w_k1u = i_curv_major;
        w_k2u = i_curv_minor;
        w_k1m = w_k1u[31] ? (32'd0 - w_k1u) : w_k1u;
        w_k2m = w_k2u[31] ? (32'd0 - w_k2u) : w_k2u;
        if (w_k2u == '0) begin
            w_rsel = adu_pkg::RSEL_MAX;
        end else if (w_k1u == '0 || w_k1u[31] == w_k2u[31]) begin
            w_rsel = adu_pkg::RSEL_ZERO;
        end else if ({16'd0, w_k1m, 16'd0} >= {w_k2m, 32'd0}) begin
            w_rsel = adu_pkg::RSEL_MAX;
        end else begin
            w_rsel = adu_pkg::RSEL_DIV;
        end
    end

    assign w_ra_rem[0] = {16'd0, r_rsb[0].k1m[31:15]};
    assign w_ra_div[0] = r_k2m;
    assign w_ra_quo[0] = '0;

    // Cell j brings down dividend bit 30-j of |k1| * 2^16.
    for (genvar j = 0; j < RA; j++) begin : g_ratio
        localparam int IB = 30 - j;
        if (IB >= 16) begin : g_bit
            assign w_ra_bit[j] = r_rsb[j].k1m[IB-16];
        end else begin : g_zero
            assign w_ra_bit[j] = 1'b0;
        end
        adu_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_ra_rem[j]),
            .i_div (w_ra_div[j]),
            .i_quo (w_ra_quo[j]),
            .i_bit (w_ra_bit[j]),
            .o_rem (w_ra_rem[j+1]),
            .o_div (w_ra_div[j+1]),
            .o_quo (w_ra_quo[j+1])
        );
    end

    assign w_rt_rem[0]  = '0;
    assign w_rt_root[0] = '0;
    assign w_rt_rad[0]  = {16'd0, r_ratio, 16'd0};

    for (genvar j = 0; j < RC; j++) begin : g_root
        adu_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rt_rem[j]),
            .i_root (w_rt_root[j]),
            .i_rad  (w_rt_rad[j]),
            .o_rem  (w_rt_rem[j+1]),
            .o_root (w_rt_root[j+1]),
            .o_rad  (w_rt_rad[j+1])
        );
    end

    adu_unit3 u_plus (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (r_pmag),
        .i_neg  (r_pneg),
        .o_comp (w_plus)
    );

    adu_unit3 u_minus (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (r_mmag),
        .i_neg  (r_mneg),
        .o_comp (w_minus)
    );

    always_ff @(posedge i_clk) begin
        logic [41:0] v_base, v_off, v_p, v_m;
        if (w_en) begin
            r_rsb[0].rsel <= w_rsel;
            r_rsb[0].k1m  <= w_k1m;
            r_rsb[0].d1   <= {i_dir_major_z, i_dir_major_y, i_dir_major_x};
            r_rsb[0].d2   <= {i_dir_minor_z, i_dir_minor_y, i_dir_minor_x};
            r_k2m         <= w_k2m;
            for (int j = 1; j <= RA; j++) begin
                r_rsb[j] <= r_rsb[j-1];
            end

            case (r_rsb[RA].rsel)
                adu_pkg::RSEL_DIV:  r_ratio <= w_ra_quo[RA];
                adu_pkg::RSEL_ZERO: r_ratio <= '0;
                adu_pkg::RSEL_MAX:  r_ratio <= '1;
                default:            r_ratio <= '1;
            endcase
            r_rd.d1 <= r_rsb[RA].d1;
            r_rd.d2 <= r_rsb[RA].d2;

            r_tsb[0] <= r_rd;
            for (int j = 1; j < RC; j++) begin
                r_tsb[j] <= r_tsb[j-1];
            end

            for (int c = 0; c < 3; c++) begin
                r_off[c] <= $signed({1'b0, w_rt_root[RC][23:0]}) *
                            $signed(r_tsb[RC-1].d2[c]);
            end
            r_md1 <= r_tsb[RC-1].d1;

            for (int c = 0; c < 3; c++) begin
                v_base = {{10{r_md1[c][15]}}, r_md1[c], 16'd0};
                v_off  = {r_off[c][40], r_off[c]};
                v_p    = v_base + v_off;
                v_m    = v_base - v_off;
                r_pneg[c] <= v_p[41];
                r_mneg[c] <= v_m[41];
                r_pmag[c] <= v_p[41] ? MW'(42'd0 - v_p) : v_p[MW-1:0];
                r_mmag[c] <= v_m[41] ? MW'(42'd0 - v_m) : v_m[MW-1:0];
            end

            r_hyp[0] <= i_gauss_curv[31];
            for (int j = 1; j <= LAST; j++) begin
                r_hyp[j] <= r_hyp[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LAST; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= w_accept;
            for (int j = 1; j <= LAST; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_comb begin
        w_last.hyp   = r_hyp[LAST];
        w_last.plus  = r_hyp[LAST] ? w_plus  : '0;
        w_last.minus = r_hyp[LAST] ? w_minus : '0;
    end

    // The skid register is only ever full while the output register is too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_v[LAST]) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_v[LAST]) begin
            if (!r_out_valid || i_out_ready) begin
                r_out <= w_last;
            end else begin
                r_skid <= w_last;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_hyperbolic = r_out.hyp;
    assign o_asym_plus_x   = r_out.plus[0];
    assign o_asym_plus_y   = r_out.plus[1];
    assign o_asym_plus_z   = r_out.plus[2];
    assign o_asym_minus_x  = r_out.minus[0];
    assign o_asym_minus_y  = r_out.minus[1];
    assign o_asym_minus_z  = r_out.minus[2];

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without an output stall");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_hyperbolic) |->
        (o_asym_plus_x == 16'sd0 && o_asym_plus_y == 16'sd0 && o_asym_plus_z == 16'sd0 &&
         o_asym_minus_x == 16'sd0 && o_asym_minus_y == 16'sd0 &&
         o_asym_minus_z == 16'sd0))
        else $error("non-hyperbolic word carries a nonzero vector");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_asym_plus_x <= 16'sd16384 && o_asym_plus_x >= -16'sd16384 &&
         o_asym_minus_x <= 16'sd16384 && o_asym_minus_x >= -16'sd16384))
        else $error("unit vector component out of range");
`endif

endmodule

`default_nettype wire
